// ===== hdl/ctb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank package
// Shared widths, command codes and the decoded command record.
// ----------------------------------------------------------------------------
package ctb_pkg;

	localparam int CMD_W          = 2;
	localparam int ID_W           = 3;
	localparam int CNT_W          = 16;
	localparam int ID_SPAN        = 1 << ID_W;
	localparam int S_TDATA_W      = 24;
	localparam int S_TUSER_W      = CMD_W;
	localparam int M_TDATA_W      = 56;
	localparam int M_PAD_W        = M_TDATA_W - 3 - 3 * CNT_W;
	localparam int DEF_NUM_TIMERS = 8;
	localparam int DEF_SLOTS      = 5;
	localparam int Q_DEPTH        = 2;
	localparam int Q_PTR_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             hit;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] load;
	} cmd_t;

endpackage

// ===== hdl/countdown_timer_bank_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank core
// Bank of 16-bit count-down timers sharing a limited pool of running slots.
// ----------------------------------------------------------------------------
// The block takes one command per transfer (tick, start, stop or read status)
// and returns exactly one status transfer for it, describing the addressed
// timer after the command. A command is accepted every cycle when the output
// is drained; it passes through the decode register and the command queue,
// and when the executor takes it from the queue it updates all timers in
// parallel and registers the status. Back pressure on the output first fills
// the two-entry queue before the input stalls.
module countdown_timer_bank_core import ctb_pkg::*; #(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS,
	parameter int SLOTS      = DEF_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// timer_id[2:0], load_ticks[18:3], zero padding above
	input  logic [S_TDATA_W-1:0] s_tdata,
	// cmd[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// ok[0], elapsed[1], running[2], remaining[18:3], start_value[34:19],
	// elapsed_ticks[50:35], zero padding above
	output logic [M_TDATA_W-1:0] m_tdata
);

	logic push;
	cmd_t push_cmd;
	logic push_ready;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	ctb_front #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_ready(push_ready)
	);

	ctb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_ready(push_ready),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd)
	);

	ctb_back #(
		.NUM_TIMERS(NUM_TIMERS),
		.SLOTS     (SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ===== hdl/ctb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank front end
// Accepts commands, decodes them and checks the timer id, then hands them on.
// ----------------------------------------------------------------------------
module ctb_front import ctb_pkg::*; #(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 push_ready
);

	logic v_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		dec.op   = op_t'(s_tuser);
		dec.id   = s_tdata[ID_W-1:0];
		dec.load = s_tdata[ID_W+CNT_W-1:ID_W];
		dec.hit  = (int'(s_tdata[ID_W-1:0]) < NUM_TIMERS);
	end

	assign s_tready = !v_s1 || push_ready;
	assign push     = v_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (push_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// ===== hdl/ctb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank command queue
// Short FIFO of decoded commands between the front end and the executor.
// ----------------------------------------------------------------------------
module ctb_queue import ctb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	input  logic pop,
	output logic q_valid,
	output cmd_t q_cmd
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != Q_CNT_W'(Q_DEPTH));
	assign q_valid    = (count_q != '0);
	assign q_cmd      = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && q_valid;

	function automatic logic [Q_PTR_W-1:0] next_ptr(input logic [Q_PTR_W-1:0] p);
		next_ptr = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hdl/ctb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Countdown timer bank executor
// Holds the timers and the slot count, executes one command per transfer
// and registers the addressed timer's status for the output stream.
// ----------------------------------------------------------------------------
module ctb_back import ctb_pkg::*; #(
	parameter int NUM_TIMERS = DEF_NUM_TIMERS,
	parameter int SLOTS      = DEF_SLOTS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cmd_t                 q_cmd,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int NT = (NUM_TIMERS < ID_SPAN) ? NUM_TIMERS : ID_SPAN;
	localparam int SW = $clog2(SLOTS + 1);

	logic [CNT_W-1:0]     cnt_q [NT];
	logic [CNT_W-1:0]     val_q [NT];
	logic [NT-1:0]        run_q;
	logic [SW-1:0]        slots_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic [CNT_W-1:0] cnt_n [NT];
	logic [CNT_W-1:0] val_n [NT];
	logic [NT-1:0]    run_n;
	logic [NT-1:0]    sel;
	logic [SW-1:0]    slots_n;
	logic [SW-1:0]    freed;
	logic [CNT_W-1:0] cur_cnt;
	logic             cur_run;
	logic             claim;
	logic             rel;
	logic             ok;
	logic [CNT_W-1:0] res_cnt;
	logic [CNT_W-1:0] res_val;
	logic             res_run;

	always_comb begin
		cur_cnt = '0;
		cur_run = 1'b0;
		for (int t = 0; t < NT; t++) begin
			sel[t]  = q_cmd.hit && (q_cmd.id == ID_W'(t));
			cur_cnt = cur_cnt | (cnt_q[t] & {CNT_W{sel[t]}});
			cur_run = cur_run | (run_q[t] & sel[t]);
		end

		claim = 1'b0;
		rel   = 1'b0;
		ok    = 1'b1;
		unique case (q_cmd.op)
			OP_START: begin
				if (!q_cmd.hit) begin
					ok = 1'b0;
				end else if ((cur_cnt == '0) && !cur_run) begin
					if (slots_q < SW'(SLOTS)) begin
						claim = 1'b1;
					end else begin
						ok = 1'b0;
					end
				end
			end
			OP_STOP: begin
				if (q_cmd.hit && cur_run) begin
					rel = 1'b1;
				end else begin
					ok = 1'b0;
				end
			end
			OP_TICK, OP_READ: begin
			end
		endcase

		freed   = '0;
		res_cnt = '0;
		res_val = '0;
		res_run = 1'b0;
		for (int t = 0; t < NT; t++) begin
			cnt_n[t] = cnt_q[t];
			val_n[t] = val_q[t];
			run_n[t] = run_q[t];
			if ((q_cmd.op == OP_TICK) && run_q[t]) begin
				cnt_n[t] = cnt_q[t] - CNT_W'(1);
				if (cnt_q[t] == CNT_W'(1)) begin
					run_n[t] = 1'b0;
					freed    = freed + SW'(1);
				end
			end
			if ((q_cmd.op == OP_START) && sel[t]) begin
				cnt_n[t] = q_cmd.load;
				val_n[t] = q_cmd.load;
				if (claim) begin
					run_n[t] = 1'b1;
				end
			end
			if (rel && sel[t]) begin
				run_n[t] = 1'b0;
				cnt_n[t] = '0;
			end
			res_cnt = res_cnt | (cnt_n[t] & {CNT_W{sel[t]}});
			res_val = res_val | (val_n[t] & {CNT_W{sel[t]}});
			res_run = res_run | (run_n[t] & sel[t]);
		end
		slots_n = slots_q + SW'(claim) - SW'(rel) - freed;
	end

	assign q_pop    = q_valid && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '{default: '0};
			val_q      <= '{default: '0};
			run_q      <= '0;
			slots_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cnt_q   <= cnt_n;
				val_q   <= val_n;
				run_q   <= run_n;
				slots_q <= slots_n;
			end
			if (q_pop) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, res_val - res_cnt, res_val, res_cnt,
				res_run, q_cmd.hit && (res_cnt == '0), ok};
		end
	end

endmodule
